// File: hdl/fp32_adder_flush_to_zero_top_macros.svh
// Assertion macros used by the adder top file.
`ifndef FP32_ADDER_FLUSH_TO_ZERO_TOP_MACROS_SVH
`define FP32_ADDER_FLUSH_TO_ZERO_TOP_MACROS_SVH

// Consequent must hold in the cycle after the antecedent.
`define FPA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define FPA_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: hdl/fpa_pkg.sv
package fpa_pkg;

  localparam logic [31:0] QnanWord = 32'h7FC0_0000;
  localparam logic [7:0]  ExpMax   = 8'hFF;
  localparam int unsigned ExtBits  = 30;
  localparam int unsigned MantW    = 24 + ExtBits;
  localparam int unsigned SumW     = MantW + 1;

  typedef struct packed {
    logic        special;
    logic [31:0] special_word;
    logic        sign;
    logic [7:0]  exp;
    logic        sub;
    logic [MantW-1:0] mant_big;
    logic [MantW-1:0] mant_sml;
  } align_t;

  typedef struct packed {
    logic        special;
    logic [31:0] special_word;
    logic        sign;
    logic [7:0]  exp;
    logic [SumW-1:0] sum;
  } add_t;

  typedef struct packed {
    logic        special;
    logic [31:0] special_word;
    logic        sign;
    logic [9:0]  exp;
    logic [MantW-1:0] norm;
  } norm_t;

endpackage

// File: hdl/fp32_adder_flush_to_zero_top.sv
// Channel  | Dir | Fields
// s_axis   | in  | tdata[31:0] operand_a, tdata[63:32] operand_b
// m_axis   | out | tdata[31:0] sum_word
// One beat per cycle is accepted while the pipeline is not stalled.
// Latency is set by the align, add, normalize and round register stages.
// The pipeline advances whenever its output stage is empty or taken.
// Reset clears only the valid bits; a stall freezes all stages.
`include "fp32_adder_flush_to_zero_top_macros.svh"
module fp32_adder_flush_to_zero_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // operand_a, operand_b
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // sum_word
);

  logic en;
  logic out_valid;

  assign en            = !out_valid || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = out_valid;

  fpa_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .in_valid_i (s_axis_tvalid),
    .a_i        (s_axis_tdata[31:0]),
    .b_i        (s_axis_tdata[63:32]),
    .out_valid_o(out_valid),
    .sum_o      (m_axis_tdata)
  );

  `FPA_ASSERT_NEXT(a_hold_valid, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "valid dropped")
  `FPA_ASSERT_NEXT(a_hold_data, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "data changed")
  `FPA_ASSERT_NOW(a_ready, clk_i, rst_ni, !m_axis_tvalid, s_axis_tready, "stalled while empty")

endmodule

// File: hdl/fpa_datapath.sv
module fpa_datapath (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        in_valid_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic        out_valid_o,
  output logic [31:0] sum_o
);

  localparam int unsigned MW   = fpa_pkg::MantW;
  localparam int unsigned SW   = fpa_pkg::SumW;
  localparam int unsigned ExtW = fpa_pkg::ExtBits;

  logic [3:0] vld_q;
  fpa_pkg::align_t al_d, al_q;
  fpa_pkg::add_t   ad_d, ad_q;
  fpa_pkg::norm_t  nm_d, nm_q;
  logic [31:0]     res_d, res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], in_valid_i};
    end
  end

  always_comb begin
    logic [31:0] big, sml;
    logic [7:0]  be, se, d;
    logic [MW-1:0] ms, mask;
    logic        bs, ss;
    if (a_i[30:0] >= b_i[30:0]) begin
      big = a_i;
      sml = b_i;
    end else begin
      big = b_i;
      sml = a_i;
    end
    bs = big[31];
    ss = sml[31];
    be = big[30:23];
    se = sml[30:23];
    d  = be - se;
    al_d.special      = 1'b0;
    al_d.special_word = big;
    if (be == fpa_pkg::ExpMax) begin
      al_d.special = 1'b1;
      if (se == fpa_pkg::ExpMax && bs != ss) begin
        al_d.special_word = fpa_pkg::QnanWord;
      end
    end else if (se == 8'd0) begin
      al_d.special = 1'b1;
      if (be == 8'd0) begin
        al_d.special_word = {bs & ss, 31'd0};
      end
    end
    al_d.sign     = bs;
    al_d.exp      = be;
    al_d.sub      = bs ^ ss;
    al_d.mant_big = {1'b1, big[22:0], {fpa_pkg::ExtBits{1'b0}}};
    ms            = {1'b1, sml[22:0], {fpa_pkg::ExtBits{1'b0}}};
    mask          = '0;
    if (d >= 8'(MW)) begin
      al_d.mant_sml = {{(MW-1){1'b0}}, 1'b1};
    end else begin
      mask = ~({MW{1'b1}} << d[5:0]);
      al_d.mant_sml = (ms >> d[5:0]) | {{(MW-1){1'b0}}, |(ms & mask)};
    end
  end

  always_comb begin
    ad_d.special      = al_q.special;
    ad_d.special_word = al_q.special_word;
    ad_d.sign         = al_q.sign;
    ad_d.exp          = al_q.exp;
    if (al_q.sub) begin
      ad_d.sum = {1'b0, al_q.mant_big} - {1'b0, al_q.mant_sml};
    end else begin
      ad_d.sum = {1'b0, al_q.mant_big} + {1'b0, al_q.mant_sml};
    end
  end

  always_comb begin
    logic [5:0] lz;
    logic       found;
    logic [SW-1:0] sh;
    lz    = '0;
    found = 1'b0;
    sh    = '0;
    for (int i = SW - 2; i >= 0; i--) begin
      if (!found && ad_q.sum[i]) begin
        found = 1'b1;
        lz    = 6'(SW - 2 - i);
      end
    end
    nm_d.special      = ad_q.special;
    nm_d.special_word = ad_q.special_word;
    nm_d.sign         = ad_q.sign;
    if (!ad_q.special && ad_q.sum == '0) begin
      nm_d.special      = 1'b1;
      nm_d.special_word = '0;
    end
    if (ad_q.sum[SW-1]) begin
      nm_d.norm = ad_q.sum[SW-1:1] | {{(MW-1){1'b0}}, ad_q.sum[0]};
      nm_d.exp  = {2'b00, ad_q.exp} + 10'd1;
    end else begin
      sh        = ad_q.sum << lz;
      nm_d.norm = sh[MW-1:0];
      nm_d.exp  = {2'b00, ad_q.exp} - {4'd0, lz};
    end
  end

  always_comb begin
    logic [24:0] m;
    logic [ExtW-1:0] rem;
    logic [9:0]  e;
    logic        up;
    m   = {1'b0, nm_q.norm[MW-1:fpa_pkg::ExtBits]};
    rem = nm_q.norm[fpa_pkg::ExtBits-1:0];
    up  = rem[ExtW-1] & ((|rem[ExtW-2:0]) | m[0]);
    m   = m + {24'd0, up};
    e   = nm_q.exp;
    if (m[24]) begin
      m = m >> 1;
      e = e + 10'd1;
    end
    if (nm_q.special) begin
      res_d = nm_q.special_word;
    end else if (nm_q.exp[9] || nm_q.exp == 10'd0) begin
      res_d = '0;
    end else if (e >= 10'd255) begin
      res_d = {nm_q.sign, fpa_pkg::ExpMax, 23'd0};
    end else begin
      res_d = {nm_q.sign, e[7:0], m[22:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      al_q  <= al_d;
      ad_q  <= ad_d;
      nm_q  <= nm_d;
      res_q <= res_d;
    end
  end

  assign out_valid_o = vld_q[3];
  assign sum_o       = res_q;

endmodule

// File: tb/fp32_sum_checker.sv
module fp32_sum_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [31:0] InfWord  = 32'h7F80_0000;
  localparam logic [31:0] SignWord = 32'h8000_0000;
  localparam logic [22:0] FracMask = 23'h7F_FFFF;

  logic [31:0] sum_queue[$];

  function automatic logic [31:0] predict_sum(logic [31:0] a, logic [31:0] b);
    logic [31:0] big, sml;
    logic        bs, ss;
    logic [7:0]  be, se;
    logic [63:0] mb, ms, r, lost, m, rem;
    int unsigned d;
    int          p, e, sh;
    if ({a[30:0], 1'b0} >= {b[30:0], 1'b0}) begin
      big = a; sml = b;
    end else begin
      big = b; sml = a;
    end
    bs = big[31]; ss = sml[31];
    be = big[30:23]; se = sml[30:23];
    if (be == 8'hFF) begin
      if (se == 8'hFF && bs != ss) return fpa_pkg::QnanWord;
      return big;
    end
    if (se == 8'h00) begin
      if (be == 8'h00) return (bs && ss) ? SignWord : 32'h0;
      return big;
    end
    mb = {40'h0, 1'b1, big[22:0]} << 30;
    ms = {40'h0, 1'b1, sml[22:0]} << 30;
    d = int'(be) - int'(se);
    if (d >= 60) begin
      ms = 64'd1;
    end else if (d > 0) begin
      lost = ms & ((64'd1 << d) - 64'd1);
      ms = (ms >> d) | (lost != 0 ? 64'd1 : 64'd0);
    end
    r = (bs == ss) ? mb + ms : mb - ms;
    if (r == 0) return 32'h0;
    p = 63;
    while (p > 0 && r[p] == 1'b0) p--;
    e = int'(be) + (p - 53);
    if (p > 53) begin
      sh = p - 53;
      lost = r & ((64'd1 << sh) - 64'd1);
      r = (r >> sh) | (lost != 0 ? 64'd1 : 64'd0);
    end else if (p < 53) begin
      r = r << (53 - p);
    end
    if (e <= 0) return 32'h0;
    m = r >> 30;
    rem = r & ((64'd1 << 30) - 64'd1);
    if (rem > (64'd1 << 29) || (rem == (64'd1 << 29) && m[0])) m++;
    if (m == (64'd1 << 24)) begin
      m = m >> 1; e++;
    end
    if (e >= 255) return {bs, 31'h0} | InfWord;
    return {bs, e[7:0], m[22:0] & FracMask};
  endfunction

  assign pending_o = sum_queue.size();

  always @(posedge clk_i) begin
    logic [31:0] want;
    if (!rst_ni) begin
      fail_count_o <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        sum_queue.push_back(predict_sum(s_axis_tdata[31:0], s_axis_tdata[63:32]));
      if (m_axis_tvalid && m_axis_tready) begin
        if (sum_queue.size() == 0) begin
          $display("%0t: unexpected sum, expected none, actual %h", $time, m_axis_tdata);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = sum_queue.pop_front();
          if (m_axis_tdata !== want) begin
            $display("%0t: sum_word mismatch, expected %h, actual %h", $time, want,
                     m_axis_tdata);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

endmodule

// File: tb/tb_fp32_adder_flush_to_zero_top.sv
module tb_fp32_adder_flush_to_zero_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  int          fail_count;
  int          pending;
  int          idle_cycles;
  bit          stim_done;

  fp32_adder_flush_to_zero_top dut (.*);

  fp32_sum_checker checker_u (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [31:0] rand_word();
    logic [31:0] w;
    w = $urandom();
    case ($urandom_range(0, 9))
      0: w[30:23] = 8'hFF;
      1: w[30:23] = 8'h00;
      2: w[30:23] = 8'($urandom_range(1, 3));
      3: w[30:23] = 8'($urandom_range(252, 254));
      default: ;
    endcase
    return w;
  endfunction

  function automatic logic [31:0] near_word(logic [31:0] base);
    logic [31:0] w;
    w = base;
    w[31] = 1'($urandom_range(0, 1));
    w[30:23] = base[30:23] - 8'($urandom_range(0, 2));
    if ($urandom_range(0, 1)) w[22:0] = base[22:0] ^ 23'($urandom() & 32'h3F);
    else w[22:0] = 23'($urandom());
    if (w[30:23] == 8'h00) w[30:23] = 8'h01;
    return w;
  endfunction

  task automatic send_beat(logic [31:0] a, logic [31:0] b);
    repeat ($urandom_range(0, 8)) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {b, a};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
  endtask

  initial begin
    logic [31:0] a, b;
    logic [31:0] dir_a[] = '{32'h0000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0000_0001,
      32'h3F80_0000, 32'h7F80_0000, 32'h7F80_0000, 32'h7F80_0000, 32'h7FA0_0001,
      32'h3F80_0000, 32'h3F80_0000, 32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h0080_0000,
      32'h0080_0001, 32'h3F80_0000, 32'h4B80_0000, 32'h3F80_0001, 32'hFFFF_FFFF,
      32'h7FFF_FFFF, 32'h3F80_0000};
    logic [31:0] dir_b[] = '{32'h0000_0000, 32'h8000_0000, 32'h0000_0000, 32'h807F_FFFF,
      32'h0000_0000, 32'hFF80_0000, 32'h7F80_0000, 32'hFFC0_0000, 32'h3F80_0000,
      32'hBF80_0000, 32'h3380_0000, 32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h8080_0001,
      32'h8080_0000, 32'h3F80_0000, 32'h3F80_0000, 32'h3380_0000, 32'h0000_0000,
      32'h8000_0001, 32'h3400_0000};
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    foreach (dir_a[i]) send_beat(dir_a[i], dir_b[i]);
    for (int n = 0; n < 800; n++) begin
      if (n == 400) begin
        while (pending != 0) @(negedge clk_i);
      end
      a = rand_word();
      case ($urandom_range(0, 3))
        0, 1: b = near_word(a);
        default: b = rand_word();
      endcase
      send_beat(a, b);
    end
    stim_done = 1'b1;
  end

  initial begin
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(0, 8)) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= 2000) begin
        $display("FAIL fp32_adder_flush_to_zero_top");
        $finish;
      end
      if (stim_done && pending == 0) begin
        repeat (20) @(posedge clk_i);
        if (fail_count == 0 && pending == 0) begin
          $display("PASS fp32_adder_flush_to_zero_top");
        end else begin
          $display("FAIL fp32_adder_flush_to_zero_top");
        end
        $finish;
      end
    end
  end
endmodule
